// ----- sv/pcss_pkg.sv -----
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types, constants, microcode table and crc helper for the
// double-buffered settings store.
// ----------------------------------------------------------------------------
package pcss_pkg;

    // record layout, little-endian, 20 bytes
    localparam int REC_W      = 160;
    localparam int BODY_W     = 144;        // bytes 0..17, covered by the crc
    localparam int SET_W      = 16;
    localparam int NUM_SET    = 6;
    localparam int SETS_W     = SET_W * NUM_SET;
    localparam int SEQ_W      = 32;
    localparam int CRC_W      = 16;
    localparam int CRC_SPAN   = 18;
    localparam int CNT_W      = 5;
    localparam int STEP_W     = 4;

    localparam logic [CNT_W-1:0]  CRC_LAST  = CNT_W'(CRC_SPAN - 1);
    localparam logic [15:0]       REC_MAGIC = 16'h5748;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [REC_W-1:0]  REC_ERASED = {REC_W{1'b1}};
    localparam logic [SEQ_W-1:0]  SEQ_FIRST = 32'd1;

    // slot_written codes
    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_A    = 2'd1;
    localparam logic [1:0] SLOT_B    = 2'd2;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SAVE = 1'b1;

    // byte source for the crc unit
    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_REC
    } t_src;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_CNT_MORE,
        C_IS_LOAD,
        C_IS_SAME,
        C_OUT_BUSY
    } t_cond;

    // step addresses of the program
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_A_INIT   = 4'd1;
    localparam logic [STEP_W-1:0] ST_A_CRC    = 4'd2;
    localparam logic [STEP_W-1:0] ST_A_CHK    = 4'd3;
    localparam logic [STEP_W-1:0] ST_B_INIT   = 4'd4;
    localparam logic [STEP_W-1:0] ST_B_CRC    = 4'd5;
    localparam logic [STEP_W-1:0] ST_B_CHK    = 4'd6;
    localparam logic [STEP_W-1:0] ST_PICK     = 4'd7;
    localparam logic [STEP_W-1:0] ST_OPC      = 4'd8;
    localparam logic [STEP_W-1:0] ST_SAME     = 4'd9;
    localparam logic [STEP_W-1:0] ST_BUILD    = 4'd10;
    localparam logic [STEP_W-1:0] ST_R_CRC    = 4'd11;
    localparam logic [STEP_W-1:0] ST_COMMIT   = 4'd12;
    localparam logic [STEP_W-1:0] ST_RES_LOAD = 4'd13;
    localparam logic [STEP_W-1:0] ST_RES_SAME = 4'd14;
    localparam logic [STEP_W-1:0] ST_EMIT     = 4'd15;

    typedef struct packed {
        logic              crc_init;
        logic              crc_step;
        t_src              src;
        logic              chk_a;
        logic              chk_b;
        logic              pick;
        logic              build;
        logic              commit;
        logic              res_load;
        logic              res_same;
        logic              load_out;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // datapath status used by the jump logic
    typedef struct packed {
        logic cnt_more;
        logic is_load;
        logic is_same;
    } t_dp_stat;

    typedef struct packed {
        logic              success;
        logic [1:0]        slot;
        logic [SETS_W-1:0] sets;
    } t_result;

    function automatic t_uword uw_nop();
        t_uword w;
        w = '0;
        w.src    = SRC_A;
        w.cond   = C_NEXT;
        w.target = ST_IDLE;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = uw_nop();
        case (step)
            ST_IDLE: begin
                w.cond = C_NO_START; w.target = ST_IDLE;
            end
            ST_A_INIT:   w.crc_init = 1'b1;
            ST_A_CRC: begin
                w.crc_step = 1'b1; w.src = SRC_A;
                w.cond = C_CNT_MORE; w.target = ST_A_CRC;
            end
            ST_A_CHK:    w.chk_a = 1'b1;
            ST_B_INIT:   w.crc_init = 1'b1;
            ST_B_CRC: begin
                w.crc_step = 1'b1; w.src = SRC_B;
                w.cond = C_CNT_MORE; w.target = ST_B_CRC;
            end
            ST_B_CHK: begin
                w.chk_b = 1'b1; w.src = SRC_B;
            end
            ST_PICK:     w.pick = 1'b1;
            ST_OPC: begin
                w.cond = C_IS_LOAD; w.target = ST_RES_LOAD;
            end
            ST_SAME: begin
                w.cond = C_IS_SAME; w.target = ST_RES_SAME;
            end
            ST_BUILD: begin
                w.build = 1'b1; w.crc_init = 1'b1;
            end
            ST_R_CRC: begin
                w.crc_step = 1'b1; w.src = SRC_REC;
                w.cond = C_CNT_MORE; w.target = ST_R_CRC;
            end
            ST_COMMIT: begin
                w.commit = 1'b1; w.cond = C_ALWAYS; w.target = ST_EMIT;
            end
            ST_RES_LOAD: begin
                w.res_load = 1'b1; w.cond = C_ALWAYS; w.target = ST_EMIT;
            end
            ST_RES_SAME: w.res_same = 1'b1;
            ST_EMIT: begin
                w.load_out = 1'b1; w.cond = C_OUT_BUSY; w.target = ST_EMIT;
            end
            default: w = uw_nop();
        endcase
        return w;
    endfunction

    // one byte of crc-16/modbus, reflected
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/pcss_seq.sv -----
// ----------------------------------------------------------------------------
// pcss_seq
// Microcode sequencer: step counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
module pcss_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_busy,
    input  pcss_pkg::t_dp_stat i_stat,
    output pcss_pkg::t_uword  o_uword,
    output logic              o_idle
);
    import pcss_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              take;

    assign uw      = ucode(r_step);
    assign o_uword = uw;
    assign o_idle  = (r_step == ST_IDLE);

    always_comb begin
        case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !i_start;
            C_CNT_MORE: take = i_stat.cnt_more;
            C_IS_LOAD:  take = i_stat.is_load;
            C_IS_SAME:  take = i_stat.is_same;
            C_OUT_BUSY: take = i_out_busy;
            default:    take = 1'b0;
        endcase
    end

    // last step wraps back to idle
    assign n_step = take ? uw.target : r_step + STEP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- sv/pcss_dp.sv -----
// ----------------------------------------------------------------------------
// pcss_dp
// Datapath: two record slots, bytewise crc unit, slot selection and
// record build, driven by the control word.
// ----------------------------------------------------------------------------
module pcss_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcss_pkg::t_uword            i_uword,
    input  logic                        i_start,
    input  logic                        i_opcode,
    input  logic [pcss_pkg::SETS_W-1:0] i_sets,
    output pcss_pkg::t_dp_stat          o_stat,
    output pcss_pkg::t_result           o_result
);
    import pcss_pkg::*;

    logic [REC_W-1:0]  r_slot_a;
    logic [REC_W-1:0]  r_slot_b;
    logic              r_op;
    logic [SETS_W-1:0] r_sets;
    logic [CRC_W-1:0]  r_crc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_va;
    logic              r_vb;
    logic              r_cur_b;
    logic              r_cur_ok;
    logic              r_tgt_b;
    logic [BODY_W-1:0] r_rec;
    t_result           r_res;

    logic [REC_W-1:0]  src_rec;
    logic [7:0]        src_byte;
    logic [REC_W-1:0]  cur_rec;
    logic              rec_ok;
    logic              cur_b;
    logic [SEQ_W-1:0]  new_seq;

    always_comb begin
        case (i_uword.src)
            SRC_A:   src_rec = r_slot_a;
            SRC_B:   src_rec = r_slot_b;
            SRC_REC: src_rec = {{(REC_W-BODY_W){1'b0}}, r_rec};
            default: src_rec = r_slot_a;
        endcase
    end

    assign src_byte = src_rec[{r_cnt, 3'b000} +: 8];
    assign cur_rec  = r_cur_b ? r_slot_b : r_slot_a;
    // magic and stored crc of the slot just scanned
    assign rec_ok   = (src_rec[143:128] == REC_MAGIC) && (src_rec[159:144] == r_crc);
    assign cur_b    = r_vb && (!r_va || (r_slot_a[SEQ_W-1:0] < r_slot_b[SEQ_W-1:0]));
    assign new_seq  = r_cur_ok ? cur_rec[SEQ_W-1:0] + SEQ_W'(1) : SEQ_FIRST;

    assign o_stat.cnt_more = (r_cnt != CRC_LAST);
    assign o_stat.is_load  = (r_op == OP_LOAD);
    assign o_stat.is_same  = r_cur_ok && (cur_rec[SEQ_W +: SETS_W] == r_sets);
    assign o_result        = r_res;

    // record slots, erased after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_a <= REC_ERASED;
            r_slot_b <= REC_ERASED;
        end else if (i_uword.commit) begin
            if (r_tgt_b) begin
                r_slot_b <= {r_crc, r_rec};
            end else begin
                r_slot_a <= {r_crc, r_rec};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_opcode;
            r_sets <= i_sets;
        end
        if (i_uword.crc_init) begin
            r_crc <= CRC_INIT;
            r_cnt <= '0;
        end else if (i_uword.crc_step) begin
            r_crc <= crc_byte(r_crc, src_byte);
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_uword.chk_a) begin
            r_va <= rec_ok;
        end
        if (i_uword.chk_b) begin
            r_vb <= rec_ok;
        end
        if (i_uword.pick) begin
            r_cur_b  <= cur_b;
            r_cur_ok <= r_va || r_vb;
        end
        if (i_uword.build) begin
            r_rec   <= {REC_MAGIC, r_sets, new_seq};
            r_tgt_b <= r_cur_ok && !r_cur_b;
        end
        if (i_uword.commit) begin
            r_res.success <= 1'b1;
            r_res.slot    <= r_tgt_b ? SLOT_B : SLOT_A;
            r_res.sets    <= '0;
        end else if (i_uword.res_load) begin
            r_res.success <= r_cur_ok;
            r_res.slot    <= SLOT_NONE;
            r_res.sets    <= r_cur_ok ? cur_rec[SEQ_W +: SETS_W] : '0;
        end else if (i_uword.res_same) begin
            r_res.success <= 1'b1;
            r_res.slot    <= SLOT_NONE;
            r_res.sets    <= '0;
        end
    end

endmodule

// ----- sv/pingpong_crc_settings_store_top.sv -----
// ----------------------------------------------------------------------------
// pingpong_crc_settings_store_top
// Double-buffered settings store: two crc-16/modbus protected records,
// load of the newest valid one, save into the other slot, or slot A if none is valid.
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake                 payload
//  input     in          i_in_valid / o_in_stall   opcode + six settings
//  output    out         o_out_valid / i_out_stall success, slot, six settings
//
//  one beat at a time: a load runs the bytewise crc unit over both slots and
//  picks the newest valid record; a save does the same, ends when settings
//  are unchanged and otherwise builds a new record, runs the crc over it and
//  writes it into a slot
//  the result sits in an output register, so the next beat is accepted while
//  a finished result still waits; a stalled result holds the sequencer at its
//  last step until the register frees
//  synchronous active-low reset puts both slots to erased all-ones
//
module pingpong_crc_settings_store_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_offset_in,
    input  logic [15:0] i_window_in,
    input  logic [15:0] i_average_in,
    input  logic [15:0] i_cutoff_in,
    input  logic [15:0] i_calibration_in,
    input  logic [15:0] i_pulses_per_rev_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_success,
    output logic [1:0]  o_slot_written,
    output logic [15:0] o_offset_out,
    output logic [15:0] o_window_out,
    output logic [15:0] o_average_out,
    output logic [15:0] o_cutoff_out,
    output logic [15:0] o_calibration_out,
    output logic [15:0] o_pulses_per_rev_out
);
    import pcss_pkg::*;

    t_uword            uw;
    t_dp_stat          stat;
    t_result           res;
    logic              idle;
    logic              start;
    logic              out_busy;
    logic              load_out;
    logic [SETS_W-1:0] sets_in;

    logic              r_out_valid;
    t_result           r_out;

    // a beat is taken only when the program sits at its first step
    assign o_in_stall = !idle;
    assign start      = i_in_valid && idle;

    // settings packed in record order, offset lowest
    assign sets_in = {i_pulses_per_rev_in, i_calibration_in, i_cutoff_in,
                      i_average_in, i_window_in, i_offset_in};

    // output register still holds an untaken beat
    assign out_busy = r_out_valid && i_out_stall;
    assign load_out = uw.load_out && !out_busy;

    pcss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_busy (out_busy),
        .i_stat     (stat),
        .o_uword    (uw),
        .o_idle     (idle)
    );

    pcss_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uw),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sets   (sets_in),
        .o_stat   (stat),
        .o_result (res)
    );

    // output register, valid cleared when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_success            = r_out.success;
    assign o_slot_written       = r_out.slot;
    assign o_offset_out         = r_out.sets[0*SET_W +: SET_W];
    assign o_window_out         = r_out.sets[1*SET_W +: SET_W];
    assign o_average_out        = r_out.sets[2*SET_W +: SET_W];
    assign o_cutoff_out         = r_out.sets[3*SET_W +: SET_W];
    assign o_calibration_out    = r_out.sets[4*SET_W +: SET_W];
    assign o_pulses_per_rev_out = r_out.sets[5*SET_W +: SET_W];

endmodule
